@@ rtl/grid_local_minimum_marker_unit_defines.svh @@
// Assertion macros shared by the grid local minimum marker RTL.
// Included by every module that carries concurrent assertions; no dependencies.
`ifndef GRID_LOCAL_MINIMUM_MARKER_UNIT_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_MARKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define GLMM_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("glmm assertion failed");

`define GLMM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("glmm implication failed");

`define GLMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("glmm next-cycle check failed");

`else

`define GLMM_ASSERT(lbl, clk, rstn, cond)

`define GLMM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define GLMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/glmm_pkg.sv @@
// Package of the grid local minimum marker: constants, register indices and types.
// Used by every module of the block; it depends on nothing.
package glmm_pkg;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int WIDTH_REG_W  = 6;
    localparam int HEIGHT_REG_W = 11;
    localparam int ROW_W        = 10;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_REG_W;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(5);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    // Which neighbours of the centre pixel lie inside the frame.
    typedef struct packed {
        logic up_ok;
        logic dn_ok;
        logic lf_ok;
        logic rt_ok;
    } t_nbr_mask;

endpackage

@@ rtl/glmm_line_store.sv @@
// Line store of the grid local minimum marker: a shift line whose write position follows
// the frame width, read at its two lowest entries. Depends on glmm_pkg only for parameter defaults.
module glmm_line_store #(
    parameter int MAX_WIDTH  = glmm_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = glmm_pkg::DEF_PIXEL_BITS,
    parameter int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic [COL_W-1:0]      i_wpos,
    input  logic [PIXEL_BITS-1:0] i_din,
    output logic [PIXEL_BITS-1:0] o_tap0,
    output logic [PIXEL_BITS-1:0] o_tap1
);

    localparam int TAP1 = (MAX_WIDTH > 1) ? 1 : 0;

    logic [PIXEL_BITS-1:0] r_line [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] n_line [MAX_WIDTH];

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            if (COL_W'(i) == i_wpos) begin
                n_line[i] = i_din;
            end else if (i < MAX_WIDTH - 1) begin
                n_line[i] = r_line[(i < MAX_WIDTH - 1) ? i + 1 : i];
            end else begin
                n_line[i] = r_line[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_line <= n_line;
        end
    end

    assign o_tap0 = r_line[0];
    assign o_tap1 = r_line[TAP1];

endmodule

@@ rtl/glmm_min_eval.sv @@
// Strict four-neighbour minimum test of the grid local minimum marker.
// Depends on glmm_pkg for the neighbour mask type.
module glmm_min_eval #(
    parameter int PIXEL_BITS = glmm_pkg::DEF_PIXEL_BITS
) (
    input  logic [PIXEL_BITS-1:0] i_val,
    input  logic [PIXEL_BITS-1:0] i_up,
    input  logic [PIXEL_BITS-1:0] i_dn,
    input  logic [PIXEL_BITS-1:0] i_lf,
    input  logic [PIXEL_BITS-1:0] i_rt,
    input  glmm_pkg::t_nbr_mask   i_mask,
    output logic                  o_is_min
);

    always_comb begin
        o_is_min = (!i_mask.up_ok || (i_val < i_up)) &&
                   (!i_mask.dn_ok || (i_val < i_dn)) &&
                   (!i_mask.lf_ok || (i_val < i_lf)) &&
                   (!i_mask.rt_ok || (i_val < i_rt));
    end

endmodule

@@ rtl/glmm_out_buf.sv @@
// Output register with a skid stage for the grid local minimum marker results.
// Depends on the assertion macro header, and on glmm_pkg for the default data width.
`include "grid_local_minimum_marker_unit_defines.svh"

module glmm_out_buf #(
    parameter int DATA_W = glmm_pkg::DEF_PIXEL_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_space,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    logic              load;

    assign load    = !r_out_valid || i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    `GLMM_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push, !r_skid_valid)
    `GLMM_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `GLMM_ASSERT_NEXT(a_skid_drains_to_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

endmodule

@@ rtl/grid_local_minimum_marker_unit.sv @@
// Top level of the grid local minimum marker: position counters, end-of-frame flush and
// configuration. Depends on glmm_pkg, glmm_line_store, glmm_min_eval, glmm_out_buf.
//
// Usage: pixels enter in raster order on i_pixel with the i_valid / o_ready handshake, one
// transaction per pixel. Each result transaction on o_valid / i_ready carries a centre pixel,
// its strict four-neighbour minimum flag and an end-of-frame mark. A pixel of row r is
// reported, one row behind the input, once the pixel below it is accepted. Throughput is
// one pixel per cycle while o_ready is high, set by the two shift-line stores that hold
// the previous two rows. The final pixel of a frame also starts a flush of the last row
// that emits one result per cycle while the output stage has room, one per column of the
// frame; o_ready is low during the flush. Configuration writes to the width or height
// index take effect at once and restart the frame; the user must make them only while
// the block is idle, and the block does not enforce this. Reset clears the counters,
// empties the output stage and loads width and height of 5; the line stores are not
// cleared. When the receiver stalls, one further result is held in a skid stage and
// o_ready falls only once that stage is occupied.
`include "grid_local_minimum_marker_unit_defines.svh"

module grid_local_minimum_marker_unit #(
    parameter int MAX_WIDTH  = glmm_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = glmm_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [PIXEL_BITS-1:0]           i_pixel,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [PIXEL_BITS-1:0]           o_pixel_value,
    output logic                            o_is_local_min,
    output logic                            o_last_of_frame,
    input  logic                            i_cfg_we,
    input  logic [glmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [glmm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W = glmm_pkg::WIDTH_REG_W + 1;
    localparam int ROW_W  = glmm_pkg::ROW_W;
    localparam int HREG_W = glmm_pkg::HEIGHT_REG_W;
    localparam int DATA_W = PIXEL_BITS + 2;

    logic [glmm_pkg::WIDTH_REG_W-1:0] r_width;
    logic [HREG_W-1:0]                r_height;
    logic [COL_W-1:0]                 r_col, n_col;
    logic [ROW_W-1:0]                 r_row, n_row;
    logic                             r_flush, n_flush;
    logic [COL_W-1:0]                 r_fcol, n_fcol;
    logic [PIXEL_BITS-1:0]            r_left;

    logic [WEFF_W-1:0]     w_eff;
    logic [COL_W-1:0]      w_m1;
    logic [HREG_W-1:0]     h_eff;
    logic [ROW_W-1:0]      h_m1;
    logic                  space;
    logic                  accept;
    logic                  flush_emit;
    logic                  shift;
    logic                  push;
    logic                  cfg_hit;
    logic                  last;
    logic                  is_min;
    glmm_pkg::t_nbr_mask   mask;
    logic [PIXEL_BITS-1:0] c_din;
    logic [PIXEL_BITS-1:0] c_tap0, c_tap1, u_tap0, u_tap1;
    logic [DATA_W-1:0]     res_data, out_data;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WEFF_W'(1);
        end else if (WEFF_W'(r_width) > WEFF_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(r_width);
        end
        w_m1 = COL_W'(w_eff - WEFF_W'(1));

        if (r_height == '0) begin
            h_eff = HREG_W'(1);
        end else if (r_height > HREG_W'(glmm_pkg::HEIGHT_LIMIT)) begin
            h_eff = HREG_W'(glmm_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
        h_m1 = ROW_W'(h_eff - HREG_W'(1));
    end

    assign o_ready    = space && !r_flush;
    assign accept     = i_valid && o_ready;
    assign flush_emit = r_flush && space;
    assign shift      = accept || flush_emit;
    assign push       = flush_emit || (accept && (r_row != '0));
    assign c_din      = r_flush ? c_tap0 : i_pixel;
    assign last       = r_flush && (r_fcol == w_m1);

    always_comb begin
        if (r_flush) begin
            mask.up_ok = (h_m1 != '0);
            mask.dn_ok = 1'b0;
            mask.lf_ok = (r_fcol != '0);
            mask.rt_ok = (r_fcol != w_m1);
        end else begin
            mask.up_ok = (r_row[ROW_W-1:1] != '0);
            mask.dn_ok = 1'b1;
            mask.lf_ok = (r_col != '0);
            mask.rt_ok = (r_col != w_m1);
        end
    end

    always_comb begin
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                glmm_pkg::CFG_IMAGE_WIDTH:  cfg_hit = 1'b1;
                glmm_pkg::CFG_IMAGE_HEIGHT: cfg_hit = 1'b1;
                default:                    cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        n_fcol  = r_fcol;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (r_col == w_m1) begin
                n_col = '0;
                if (r_row == h_m1) begin
                    n_row   = '0;
                    n_flush = 1'b1;
                    n_fcol  = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        if (flush_emit) begin
            if (r_fcol == w_m1) begin
                n_flush = 1'b0;
            end else begin
                n_fcol = r_fcol + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= glmm_pkg::WIDTH_RESET;
            r_height <= glmm_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_flush  <= 1'b0;
            r_fcol   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    glmm_pkg::CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data[glmm_pkg::WIDTH_REG_W-1:0];
                    end
                    glmm_pkg::CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data[HREG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
            r_fcol  <= n_fcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_left <= c_tap0;
        end
    end

    glmm_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_centre_line (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_wpos  (w_m1),
        .i_din   (c_din),
        .o_tap0  (c_tap0),
        .o_tap1  (c_tap1)
    );

    glmm_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_wpos  (w_m1),
        .i_din   (c_tap0),
        .o_tap0  (u_tap0),
        .o_tap1  (u_tap1)
    );

    glmm_min_eval #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_min_eval (
        .i_val    (c_tap0),
        .i_up     (u_tap0),
        .i_dn     (i_pixel),
        .i_lf     (r_left),
        .i_rt     (c_tap1),
        .i_mask   (mask),
        .o_is_min (is_min)
    );

    assign res_data = {c_tap0, is_min, last};

    glmm_out_buf #(
        .DATA_W (DATA_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res_data),
        .o_space (space),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_ready (i_ready)
    );

    assign o_pixel_value   = out_data[DATA_W-1:2];
    assign o_is_local_min  = out_data[1];
    assign o_last_of_frame = out_data[0];

    // The upper tap of the second line is not needed; it only ties off the port.
    logic unused_tap;
    assign unused_tap = ^u_tap1;

    `GLMM_ASSERT_IMPL(a_no_accept_in_flush, i_clk, i_rst_n, r_flush, !o_ready)
    `GLMM_ASSERT(a_col_in_range, i_clk, i_rst_n, (r_col <= w_m1) || $past(i_cfg_we))
    `GLMM_ASSERT_IMPL(a_fcol_in_range, i_clk, i_rst_n, r_flush && !$past(i_cfg_we),
                      (r_fcol <= w_m1) && !unused_tap || (r_fcol <= w_m1))

endmodule

@@ tb/grid_local_minimum_marker_unit_test.sv @@
// Self-checking testbench for grid_local_minimum_marker_unit: pixel frames in, marked pixels out.
// Needs glmm_pkg and the block's RTL; a built-in line-store predictor supplies the expected marks.
`timescale 1ns / 1ps

module grid_local_minimum_marker_unit_test;

    localparam int PW             = glmm_pkg::DEF_PIXEL_BITS;
    localparam int MAXW           = glmm_pkg::DEF_MAX_WIDTH;
    localparam int CIW            = glmm_pkg::CFG_IDX_W;
    localparam int CDW            = glmm_pkg::CFG_DATA_W;
    localparam int WRW            = glmm_pkg::WIDTH_REG_W;
    localparam int HRW            = glmm_pkg::HEIGHT_REG_W;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PIXELS  = 190;
    localparam int TALL_PIXELS    = 24;
    localparam logic [CIW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CIW-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [PW-1:0] pixel_value;
        logic          is_local_min;
        logic          last_of_frame;
    } t_mark;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PW-1:0]         i_pixel = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PW-1:0]         o_pixel_value;
    logic                  o_is_local_min;
    logic                  o_last_of_frame;
    logic                  i_cfg_we = 1'b0;
    logic [CIW-1:0]        i_cfg_index = '0;
    logic [CDW-1:0]        i_cfg_data = '0;

    // Predictor state: line stores, position and the two registers.
    logic [PW-1:0]           upper_line [MAXW];
    logic [PW-1:0]           centre_line [MAXW];
    int                      column_pos = 0;
    int                      row_pos = 0;
    logic [WRW-1:0]          width_reg = glmm_pkg::WIDTH_RESET;
    logic [HRW-1:0]          height_reg = glmm_pkg::HEIGHT_RESET;

    t_mark expected_marks[$];
    int    mismatch_count = 0;
    int    burst_left = 0;
    int    stall_mode = 0;
    int    stall_left = 0;

    grid_local_minimum_marker_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel         (i_pixel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_value   (o_pixel_value),
        .o_is_local_min  (o_is_local_min),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int frame_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return int'(width_reg);
    endfunction

    function automatic int frame_height();
        if (height_reg == 0) return 1;
        if (height_reg > glmm_pkg::HEIGHT_LIMIT) return glmm_pkg::HEIGHT_LIMIT;
        return int'(height_reg);
    endfunction

    function automatic logic strict_min(logic [PW-1:0] val,
                                        bit up_ok, logic [PW-1:0] up,
                                        bit dn_ok, logic [PW-1:0] dn,
                                        bit lf_ok, logic [PW-1:0] lf,
                                        bit rt_ok, logic [PW-1:0] rt);
        return (!up_ok || val < up) && (!dn_ok || val < dn) &&
               (!lf_ok || val < lf) && (!rt_ok || val < rt);
    endfunction

    function automatic void push_mark(logic [PW-1:0] val, logic flag, logic last);
        t_mark m;
        m.pixel_value   = val;
        m.is_local_min  = flag;
        m.last_of_frame = last;
        expected_marks.push_back(m);
    endfunction

    // The pixel one row below a centre pixel completes it; the frame's last pixel flushes
    // the final row.
    function automatic void predict_marks(logic [PW-1:0] px);
        int w;
        int h;
        int c;
        int r;
        w = frame_width();
        h = frame_height();
        c = column_pos;
        r = row_pos;
        if (r >= 1) begin
            push_mark(centre_line[c],
                      strict_min(centre_line[c], r >= 2, upper_line[c], 1'b1, px,
                                 c > 0, (c > 0) ? upper_line[c-1] : '0,
                                 c + 1 < w, (c + 1 < w) ? centre_line[c+1] : '0),
                      1'b0);
        end
        upper_line[c]  = centre_line[c];
        centre_line[c] = px;
        if (c + 1 >= w) begin
            column_pos = 0;
            if (r + 1 >= h) begin
                for (int j = 0; j < w; j++) begin
                    push_mark(centre_line[j],
                              strict_min(centre_line[j], h > 1, upper_line[j], 1'b0, '0,
                                         j > 0, (j > 0) ? centre_line[j-1] : '0,
                                         j + 1 < w, (j + 1 < w) ? centre_line[j+1] : '0),
                              j + 1 == w);
                end
                row_pos = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            column_pos = c + 1;
        end
    endfunction

    function automatic logic [PW-1:0] random_pixel(int style);
        case (style)
            0: return PW'($urandom_range(0, 255));
            1: return PW'($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return PW'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [PW-1:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        predict_marks(px);
    endtask

    task automatic send_frame(input int count, input int style);
        for (int k = 0; k < count; k++) send_pixel(random_pixel(style));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_marks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CIW-1:0] index,
                                  input logic [CDW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == glmm_pkg::CFG_IMAGE_WIDTH) begin
            width_reg  = data[WRW-1:0];
            column_pos = 0;
            row_pos    = 0;
        end else if (index == glmm_pkg::CFG_IMAGE_HEIGHT) begin
            height_reg = data;
            column_pos = 0;
            row_pos    = 0;
        end
        @(posedge i_clk);
    endtask

    task automatic test_reset_frame();
        logic [PW-1:0] pattern [25] = '{
            8'd0,   8'd255, 8'd7,   8'd7,   8'd0,
            8'd255, 8'd3,   8'd9,   8'd6,   8'd255,
            8'd128, 8'd255, 8'd0,   8'd255, 8'd127,
            8'd1,   8'd2,   8'd255, 8'd1,   8'd254,
            8'd0,   8'd255, 8'd128, 8'd2,   8'd255
        };
        foreach (pattern[k]) send_pixel(pattern[k]);
    endtask

    task automatic test_single_pixel();
        wait_idle();
        write_register(glmm_pkg::CFG_IMAGE_WIDTH, '0);
        write_register(glmm_pkg::CFG_IMAGE_HEIGHT, '0);
        send_pixel('0);
        send_pixel('1);
    endtask

    task automatic test_write_restart();
        wait_idle();
        write_register(glmm_pkg::CFG_IMAGE_WIDTH, 11'd3);
        write_register(glmm_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        send_frame(4, 0);
        wait_idle();
        write_register(CFG_SPARE_A, CDW'($urandom));
        send_frame(1, 2);
        wait_idle();
        write_register(CFG_SPARE_B, '1);
        send_frame(1, 1);
        send_frame(2, 0);
        wait_idle();
        write_register(glmm_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        send_frame(9, 1);
    endtask

    task automatic test_large_frames();
        wait_idle();
        write_register(glmm_pkg::CFG_IMAGE_WIDTH, 11'h03F);
        write_register(glmm_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        send_frame(2 * MAXW, 0);
        wait_idle();
        write_register(glmm_pkg::CFG_IMAGE_WIDTH, 11'h7C1);
        write_register(glmm_pkg::CFG_IMAGE_HEIGHT, 11'h7FF);
        send_frame(TALL_PIXELS, 1);
    endtask

    task automatic test_random_frames();
        int sent;
        int wsel;
        int hsel;
        int total;
        int count;
        bit must_write;
        sent = 0;
        must_write = 1'b1;
        while (sent < RANDOM_PIXELS) begin
            if (must_write || $urandom_range(0, 2) != 0) begin
                wait_idle();
                if ($urandom_range(0, 7) == 0) begin
                    write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                   CDW'($urandom));
                end
                case ($urandom_range(0, 9))
                    0:       wsel = 0;
                    1:       wsel = $urandom_range(33, 63);
                    2, 3:    wsel = $urandom_range(7, 32);
                    default: wsel = $urandom_range(1, 6);
                endcase
                if (wsel > 16) hsel = $urandom_range(1, 3);
                else if ($urandom_range(0, 9) == 0) hsel = 0;
                else if ($urandom_range(0, 4) == 0) hsel = $urandom_range(5, 9);
                else hsel = $urandom_range(1, 4);
                write_register(glmm_pkg::CFG_IMAGE_WIDTH, {5'($urandom), 6'(wsel)});
                write_register(glmm_pkg::CFG_IMAGE_HEIGHT, CDW'(hsel));
            end
            total = frame_width() * frame_height();
            must_write = ($urandom_range(0, 9) == 0);
            count = must_write ? $urandom_range(0, total - 1) : total;
            send_frame(count, $urandom_range(0, 2));
            sent += count;
        end
    endtask

    // Receiver: free-flowing, light, heavy and near-blocked stretches in random order.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        case (stall_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ($urandom_range(0, 1) != 0);
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_marks
        t_mark want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_marks.size() == 0) begin
                $error("unexpected result transaction: pixel_value %0d", o_pixel_value);
                mismatch_count++;
            end else begin
                want = expected_marks.pop_front();
                if (o_pixel_value !== want.pixel_value) begin
                    $error("pixel_value: expected %0d, got %0d",
                           want.pixel_value, o_pixel_value);
                    mismatch_count++;
                end
                if (o_is_local_min !== want.is_local_min) begin
                    $error("is_local_min: expected %0b, got %0b",
                           want.is_local_min, o_is_local_min);
                    mismatch_count++;
                end
                if (o_last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, got %0b",
                           want.last_of_frame, o_last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            centre_line[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame();
        test_single_pixel();
        test_write_restart();
        test_large_frames();
        test_random_frames();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/glmm_pkg.sv
rtl/glmm_line_store.sv
rtl/glmm_min_eval.sv
rtl/glmm_out_buf.sv
rtl/grid_local_minimum_marker_unit.sv
tb/grid_local_minimum_marker_unit_test.sv
